// ===== src/dsm_pkg.sv =====
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared constants and types for the disk saturation monitor.
// ----------------------------------------------------------------------------
package dsm_pkg;

    localparam int CNT_W  = 48;
    localparam int FRAC   = 8;
    localparam int MET_W  = 24;
    localparam int PCT_W  = 15;
    localparam int DIV_W  = 64;

    localparam logic [MET_W-1:0] CAP24      = {MET_W{1'b1}};
    localparam logic [MET_W-1:0] ONE_FX     = MET_W'(1) << FRAC;
    localparam logic [MET_W-1:0] HUNDRED_FX = MET_W'(100) << FRAC;

    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_PROFILE  = 3'd1;
    localparam logic [2:0] REG_KNEE     = 3'd2;
    localparam logic [2:0] REG_BASELINE = 3'd3;
    localparam logic [2:0] REG_GROW     = 3'd4;

    localparam logic [1:0] HEALTH_OK    = 2'd0;
    localparam logic [1:0] HEALTH_WARN  = 2'd1;
    localparam logic [1:0] HEALTH_SAT   = 2'd2;
    localparam logic [1:0] HEALTH_CALIB = 2'd3;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

endpackage

// ===== src/dsm_divider.sv =====
// ----------------------------------------------------------------------------
// dsm_divider
// Restoring divider, one quotient bit per cycle, 64-bit operands.
// ----------------------------------------------------------------------------
module dsm_divider
    import dsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic [6:0]       cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic             done_reg;
    logic [DIV_W:0]   trial;

    assign trial = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== src/disk_saturation_monitor.sv =====
// ----------------------------------------------------------------------------
// disk_saturation_monitor
// Derives disk throughput, IOPS, latency and saturation health per sample.
// ----------------------------------------------------------------------------
// A reporting sample runs nine divisions one after another through a single
// radix-2 divider, each made of operand load, start, 64 quotient bits and
// capture, or of operand load and capture where the division is skipped,
// followed by one classification step that presents the result. A sample
// with no time step skips the divisions and presents its result after the
// classification step alone. Priming, failed and disabled samples are
// absorbed in idle and give no result. ready is low while a sample is in
// work or its result waits to be taken.
module disk_saturation_monitor
    import dsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              stats_ok,
    input  logic [CNT_W-1:0]  time_ms,
    input  logic [CNT_W-1:0]  sectors_rd,
    input  logic [CNT_W-1:0]  sectors_wr,
    input  logic [CNT_W-1:0]  reads_done,
    input  logic [CNT_W-1:0]  writes_done,
    input  logic [CNT_W-1:0]  write_time,
    input  logic [CNT_W-1:0]  busy_time,
    input  logic [CNT_W-1:0]  weighted_busy,
    input  logic [PCT_W-1:0]  buffer_level,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [MET_W-1:0]  wr_rate,
    output logic [MET_W-1:0]  rd_rate,
    output logic [MET_W-1:0]  wr_ops,
    output logic [MET_W-1:0]  rd_ops,
    output logic [MET_W-1:0]  capacity,
    output logic [PCT_W-1:0]  reserve,
    output logic [MET_W-1:0]  wr_latency,
    output logic [MET_W-1:0]  lat_ratio,
    output logic [MET_W-1:0]  avg_queue,
    output logic [PCT_W-1:0]  utilization,
    output logic              buf_rising,
    output logic [1:0]        health
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_CLASS = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [3:0] OP_WR   = 4'd0;
    localparam logic [3:0] OP_RD   = 4'd1;
    localparam logic [3:0] OP_WOPS = 4'd2;
    localparam logic [3:0] OP_ROPS = 4'd3;
    localparam logic [3:0] OP_LAT  = 4'd4;
    localparam logic [3:0] OP_QD   = 4'd5;
    localparam logic [3:0] OP_UTIL = 4'd6;
    localparam logic [3:0] OP_CAP  = 4'd7;
    localparam logic [3:0] OP_RAT  = 4'd8;

    logic             enable_reg;
    logic             profile_reg;
    logic [MET_W-1:0] knee_reg;
    logic [MET_W-1:0] base_reg;
    logic [7:0]       grow_samples_reg;

    logic [CNT_W-1:0] snap_reg [8];
    logic [CNT_W-1:0] delta_reg [8];
    logic             first_reg;
    logic [PCT_W-1:0] last_level_reg;
    logic [PCT_W-1:0] level_reg;
    logic [7:0]       grow_run_reg;
    logic             growing_reg;
    logic [MET_W-1:0] met_reg [10];
    logic [1:0]       health_reg;
    logic [2:0]       state_reg;
    logic [3:0]       op_reg;
    logic             skip_reg;

    div_req_t         dreq;
    div_rsp_t         drsp;
    logic [DIV_W-1:0] mul_a;
    logic [DIV_W-1:0] mul_b;
    logic [DIV_W-1:0] prod_reg;
    logic [DIV_W-1:0] den_sel;
    logic [DIV_W-1:0] q;
    logic [MET_W-1:0] qsat;
    logic             wr_cfg;
    logic             in_acc;
    logic [CNT_W-1:0] cur [8];
    logic [MET_W-1:0] base_eff;
    logic             grow_now;
    logic [7:0]       grow_run_next;
    logic             growing_next;

    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc = in_valid && in_ready;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_ENABLE:   prdata = {31'd0, enable_reg};
            REG_PROFILE:  prdata = {31'd0, profile_reg};
            REG_KNEE:     prdata = {8'd0, knee_reg};
            REG_BASELINE: prdata = {8'd0, base_reg};
            REG_GROW:     prdata = {24'd0, grow_samples_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            profile_reg      <= 1'b0;
            knee_reg         <= '0;
            base_reg         <= MET_W'(256);
            grow_samples_reg <= 8'd3;
        end
        else if (wr_cfg)
        begin
            unique case (paddr[4:2])
                REG_ENABLE:   enable_reg       <= pwdata[0];
                REG_PROFILE:  profile_reg      <= pwdata[0];
                REG_KNEE:     knee_reg         <= pwdata[MET_W-1:0];
                REG_BASELINE: base_reg         <= pwdata[MET_W-1:0];
                REG_GROW:     grow_samples_reg <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    assign cur[0] = time_ms;
    assign cur[1] = sectors_rd;
    assign cur[2] = sectors_wr;
    assign cur[3] = reads_done;
    assign cur[4] = writes_done;
    assign cur[5] = write_time;
    assign cur[6] = busy_time;
    assign cur[7] = weighted_busy;

    assign base_eff = profile_reg ? base_reg : ONE_FX;

    // operand selection for the shared multiply and divide
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        den_sel = {{(DIV_W-CNT_W){1'b0}}, delta_reg[0]};
        unique case (op_reg)
            OP_WR:
            begin
                mul_a   = DIV_W'(delta_reg[2]);
                mul_b   = DIV_W'(1000);
                den_sel = {{(DIV_W-CNT_W-3){1'b0}}, delta_reg[0], 3'b0};
            end
            OP_RD:
            begin
                mul_a   = DIV_W'(delta_reg[1]);
                mul_b   = DIV_W'(1000);
                den_sel = {{(DIV_W-CNT_W-3){1'b0}}, delta_reg[0], 3'b0};
            end
            OP_WOPS:
            begin
                mul_a = DIV_W'(delta_reg[4]);
                mul_b = DIV_W'(1000);
            end
            OP_ROPS:
            begin
                mul_a = DIV_W'(delta_reg[3]);
                mul_b = DIV_W'(1000);
            end
            OP_LAT:
            begin
                mul_a   = DIV_W'(delta_reg[5]);
                mul_b   = DIV_W'(ONE_FX);
                den_sel = DIV_W'(delta_reg[4]);
            end
            OP_QD:
            begin
                mul_a = DIV_W'(delta_reg[7]);
                mul_b = DIV_W'(ONE_FX);
            end
            OP_UTIL:
            begin
                mul_a = DIV_W'(delta_reg[6]);
                mul_b = DIV_W'(HUNDRED_FX);
            end
            OP_CAP:
            begin
                mul_a   = DIV_W'(met_reg[0]);
                mul_b   = DIV_W'(HUNDRED_FX);
                den_sel = DIV_W'(knee_reg);
            end
            OP_RAT:
            begin
                mul_a   = DIV_W'(met_reg[6]);
                mul_b   = DIV_W'(ONE_FX);
                den_sel = DIV_W'(base_eff);
            end
            default: ;
        endcase
    end

    // products fit in 64 bits only up to 2^64; wider numerators saturate below
    logic [DIV_W+16:0] prod_full;
    logic              ovf_reg;
    assign prod_full = (DIV_W+17)'(mul_a) * (DIV_W+17)'(mul_b[16:0]);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            prod_reg <= prod_full[DIV_W-1:0];
            ovf_reg  <= |prod_full[DIV_W+16:DIV_W];
        end
    end

    logic         wait_seen_reg;

    assign dreq.start = (state_reg == ST_WAIT) && !wait_seen_reg && !skip_reg;
    assign dreq.num   = prod_reg;
    assign dreq.den   = den_sel;

    dsm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign q = drsp.quo;

    always_comb
    begin
        unique case (op_reg)
            OP_UTIL:      qsat = (ovf_reg || q > DIV_W'(HUNDRED_FX)) ? HUNDRED_FX
                                                                      : q[MET_W-1:0];
            default:      qsat = (ovf_reg || |q[DIV_W-1:MET_W]) ? CAP24 : q[MET_W-1:0];
        endcase
    end

    assign grow_now = ({1'b0, level_reg} > {1'b0, last_level_reg} + 16'(5 << FRAC))
                   || (level_reg > PCT_W'(30 << FRAC));
    assign grow_run_next = grow_now ? ((grow_run_reg == 8'hFF) ? 8'hFF
                                                               : grow_run_reg + 8'd1)
                                    : 8'd0;
    assign growing_next = grow_run_next >= grow_samples_reg;

    logic         skip_now;
    logic         busy_stall;
    logic         skip_div;
    logic         wait_ready;

    always_comb
    begin
        unique case (op_reg)
            OP_LAT:  skip_now = (delta_reg[4] == '0);
            OP_CAP:  skip_now = !(profile_reg && knee_reg != '0);
            OP_RAT:  skip_now = (met_reg[6] == '0) || (base_eff == '0);
            default: skip_now = 1'b0;
        endcase
    end

    assign skip_div   = skip_reg;
    assign busy_stall = 1'b0;
    assign wait_ready = skip_div || drsp.done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_WR;
            skip_reg       <= 1'b0;
            wait_seen_reg  <= 1'b0;
            first_reg      <= 1'b1;
            last_level_reg <= '0;
            level_reg      <= '0;
            grow_run_reg   <= '0;
            growing_reg    <= 1'b0;
            health_reg     <= HEALTH_OK;
            for (int i = 0; i < 8; i++)
            begin
                snap_reg[i]  <= '0;
                delta_reg[i] <= '0;
            end
            for (int i = 0; i < 10; i++)
            begin
                met_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && enable_reg)
                    begin
                        if (!stats_ok)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                snap_reg[i] <= '0;
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                snap_reg[i]  <= cur[i];
                                delta_reg[i] <= cur[i] - snap_reg[i];
                            end
                            level_reg <= buffer_level;
                            if (first_reg)
                            begin
                                first_reg      <= 1'b0;
                                last_level_reg <= buffer_level;
                            end
                            else if (time_ms != snap_reg[0])
                            begin
                                op_reg    <= OP_WR;
                                state_reg <= ST_LOAD;
                            end
                            else
                            begin
                                state_reg <= ST_CLASS;
                            end
                        end
                    end
                end
                ST_LOAD:
                begin
                    skip_reg      <= skip_now;
                    wait_seen_reg <= 1'b0;
                    state_reg     <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    wait_seen_reg <= 1'b1;
                    if (wait_seen_reg && wait_ready && !busy_stall)
                    begin
                        unique case (op_reg)
                            OP_WR:   met_reg[0] <= qsat;
                            OP_RD:   met_reg[1] <= qsat;
                            OP_WOPS: met_reg[2] <= qsat;
                            OP_ROPS: met_reg[3] <= qsat;
                            OP_LAT:  met_reg[6] <= skip_reg ? '0 : qsat;
                            OP_QD:   met_reg[8] <= qsat;
                            OP_UTIL: met_reg[9] <= qsat;
                            OP_CAP:
                            begin
                                met_reg[4] <= skip_reg ? '0 : qsat;
                                met_reg[5] <= (skip_reg || qsat < HUNDRED_FX)
                                            ? (skip_reg ? HUNDRED_FX : HUNDRED_FX - qsat)
                                            : '0;
                            end
                            OP_RAT:  met_reg[7] <= skip_reg ? ONE_FX : qsat;
                            default: ;
                        endcase
                        op_reg    <= op_reg + 4'd1;
                        state_reg <= (op_reg == OP_RAT) ? ST_CLASS : ST_LOAD;
                    end
                end
                ST_CLASS:
                begin
                    if (!profile_reg)
                    begin
                        health_reg <= HEALTH_CALIB;
                    end
                    else
                    begin
                        grow_run_reg <= grow_run_next;
                        growing_reg  <= growing_next;
                        if (growing_next && (met_reg[4] >= MET_W'(95 << FRAC)
                                             || met_reg[7] >= MET_W'(3 << FRAC)))
                            health_reg <= HEALTH_SAT;
                        else if (met_reg[4] >= MET_W'(80 << FRAC)
                                 || (growing_next && met_reg[7] > MET_W'(3 << (FRAC - 1))))
                            health_reg <= HEALTH_WARN;
                        else
                            health_reg <= HEALTH_OK;
                    end
                    last_level_reg <= level_reg;
                    state_reg      <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid      = (state_reg == ST_OUT);
    assign wr_rate        = met_reg[0];
    assign rd_rate        = met_reg[1];
    assign wr_ops         = met_reg[2];
    assign rd_ops         = met_reg[3];
    assign capacity       = met_reg[4];
    assign reserve        = met_reg[5][PCT_W-1:0];
    assign wr_latency     = met_reg[6];
    assign lat_ratio      = met_reg[7];
    assign avg_queue      = met_reg[8];
    assign utilization    = met_reg[9][PCT_W-1:0];
    assign buf_rising     = growing_reg;
    assign health         = health_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_util_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> met_reg[9] <= HUNDRED_FX) else $error("utilisation above cap");

endmodule
